@@ sv/sadff_pkg.sv @@
// Package for the short-address data frame filter.
// Holds request types, header byte positions, filter constants and register codes.
// No dependencies.
package sadff_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  // Register decode on paddr[2]
  localparam logic REG_PAN_ID     = 1'b0;
  localparam logic REG_SHORT_ADDR = 1'b1;

  localparam logic [15:0] PAN_ID_RST     = 16'd26;
  localparam logic [15:0] SHORT_ADDR_RST = 16'd0;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Frame control checks
  localparam logic [7:0] FC0_MASK = 8'h47;
  localparam logic [7:0] FC0_WANT = 8'h41;
  localparam logic [7:0] FC1_MASK = 8'hCC;
  localparam logic [7:0] FC1_WANT = 8'h88;

  localparam logic [15:0] BROADCAST_ADDR = 16'hFFFF;
  localparam logic [7:0]  MIN_LENGTH     = 8'd11;

  // Header byte positions, counted from the length byte at zero
  localparam logic [7:0] IDX_FC0       = 8'd1;
  localparam logic [7:0] IDX_FC1       = 8'd2;
  localparam logic [7:0] IDX_SEQ       = 8'd3;
  localparam logic [7:0] IDX_PAN_LO    = 8'd4;
  localparam logic [7:0] IDX_PAN_HI    = 8'd5;
  localparam logic [7:0] IDX_DST_LO    = 8'd6;
  localparam logic [7:0] IDX_DST_HI    = 8'd7;
  localparam logic [7:0] IDX_SRC_LO    = 8'd8;
  localparam logic [7:0] IDX_SRC_HI    = 8'd9;
  localparam logic [7:0] IDX_PAYLOAD_0 = 8'd10;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_req_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic        accepted;
    logic [15:0] source_address;
    logic [15:0] dest_address;
    logic [7:0]  sequence_number;
    logic [7:0]  payload_length;
    logic        frame_last;
  } out_req_t;

endpackage

@@ sv/short_addr_data_frame_filter.sv @@
// Receive address filter for short-address data frames, one byte per request.
// Depends on sadff_pkg for request types, constants and register codes.
//
// Usage:
//   in_valid/in_stall/in_data carry one received byte per request; frame_start
//   marks the PHY length byte. out_valid/out_stall/out_data carry results:
//   payload bytes of a passing frame (FCS dropped), then one verdict request
//   with frame_last set after the frame's last byte.
//   Each byte is decoded in the cycle it is taken; its result sits in the
//   output register from the next cycle on, one byte per cycle sustained
//   unless stalled. The single output register is the only stage, so
//   in_stall is high only while a result is held and out_stall is high.
//   A new frame_start drops a frame in progress with no result; bytes outside
//   a frame are taken and discarded.
//   Reset (rst_n low, synchronous) closes any frame, empties the output
//   register and loads own_pan_id = 26, own_short_address = 0.
//   APB registers: 0x0 own_pan_id, 0x4 own_short_address (low 16 bits).
//   Write them only while no frame is in flight.
module short_addr_data_frame_filter
  import sadff_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  in_req_t           in_data,

  output logic              out_valid,
  input  logic              out_stall,
  output out_req_t          out_data,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [15:0] own_pan_r;
  logic [15:0] own_addr_r;

  logic        in_frame_r,  in_frame_nxt;
  logic [7:0]  idx_r,       idx_nxt;
  logic [7:0]  len_r,       len_nxt;
  logic        hp_r,        hp_nxt;
  logic [7:0]  seq_r,       seq_nxt;
  logic [7:0]  pan_lo_r,    pan_lo_nxt;
  logic [15:0] dst_r,       dst_nxt;
  logic [15:0] src_r,       src_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_req_t    out_data_r,  out_data_nxt;

  logic        in_fire;
  logic        cfg_wr;
  logic [7:0]  idx_inc;
  logic [15:0] pan_full;
  logic [15:0] dst_full;
  logic        emit;
  logic        payload_ok;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (paddr[2])
      REG_PAN_ID:     prdata = {{(DATA_W-16){1'b0}}, own_pan_r};
      REG_SHORT_ADDR: prdata = {{(DATA_W-16){1'b0}}, own_addr_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_pan_r  <= PAN_ID_RST;
      own_addr_r <= SHORT_ADDR_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_PAN_ID:     own_pan_r  <= pwdata[15:0];
        REG_SHORT_ADDR: own_addr_r <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  assign idx_inc  = idx_r + 8'd1;
  assign pan_full = {in_data.rx_byte, pan_lo_r};
  assign dst_full = {in_data.rx_byte, dst_r[7:0]};
  // payload runs from byte 10 up to the byte before the two FCS bytes
  assign payload_ok = (idx_inc >= IDX_PAYLOAD_0) &&
                      (({1'b0, idx_inc} + 9'd1) < {1'b0, len_r});

  always_comb begin
    in_frame_nxt  = in_frame_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    hp_nxt        = hp_r;
    seq_nxt       = seq_r;
    pan_lo_nxt    = pan_lo_r;
    dst_nxt       = dst_r;
    src_nxt       = src_r;
    emit          = 1'b0;
    out_data_nxt  = '0;

    if (in_fire) begin
      if (in_data.frame_start) begin
        in_frame_nxt = 1'b1;
        idx_nxt      = '0;
        len_nxt      = in_data.rx_byte;
        hp_nxt       = (in_data.rx_byte >= MIN_LENGTH);
        seq_nxt      = '0;
        pan_lo_nxt   = '0;
        dst_nxt      = '0;
        src_nxt      = '0;
        if (in_data.rx_byte == 8'd0) begin
          // zero length: verdict (always a reject) on the length byte
          emit                     = 1'b1;
          in_frame_nxt             = 1'b0;
          out_data_nxt.result_kind = KIND_VERDICT;
          out_data_nxt.frame_last  = 1'b1;
        end
      end else if (in_frame_r) begin
        idx_nxt = idx_inc;
        case (idx_inc)
          IDX_FC0: if ((in_data.rx_byte & FC0_MASK) != FC0_WANT) hp_nxt = 1'b0;
          IDX_FC1: if ((in_data.rx_byte & FC1_MASK) != FC1_WANT) hp_nxt = 1'b0;
          IDX_SEQ:    seq_nxt    = in_data.rx_byte;
          IDX_PAN_LO: pan_lo_nxt = in_data.rx_byte;
          IDX_PAN_HI: begin
            pan_lo_nxt = in_data.rx_byte;
            if (pan_full != own_pan_r) hp_nxt = 1'b0;
          end
          IDX_DST_LO: dst_nxt = {8'd0, in_data.rx_byte};
          IDX_DST_HI: begin
            dst_nxt = dst_full;
            if (dst_full != own_addr_r && dst_full != BROADCAST_ADDR) hp_nxt = 1'b0;
          end
          IDX_SRC_LO: src_nxt = {8'd0, in_data.rx_byte};
          IDX_SRC_HI: src_nxt = {in_data.rx_byte, src_r[7:0]};
          default: ;
        endcase

        if (idx_inc == len_r) begin
          emit                     = 1'b1;
          in_frame_nxt             = 1'b0;
          out_data_nxt.result_kind = KIND_VERDICT;
          out_data_nxt.frame_last  = 1'b1;
          if (hp_nxt) begin
            out_data_nxt.accepted        = 1'b1;
            out_data_nxt.source_address  = src_nxt;
            out_data_nxt.dest_address    = dst_nxt;
            out_data_nxt.sequence_number = seq_nxt;
            out_data_nxt.payload_length  = len_r - MIN_LENGTH;
          end
        end else if (payload_ok && hp_nxt) begin
          emit                      = 1'b1;
          out_data_nxt.result_kind  = KIND_PAYLOAD;
          out_data_nxt.payload_byte = in_data.rx_byte;
        end
      end
    end
  end

  // hold the result while stalled, else load a new one or drain
  always_comb begin
    if (emit) out_valid_nxt = 1'b1;
    else      out_valid_nxt = out_valid_r & out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      idx_r       <= '0;
      len_r       <= '0;
      hp_r        <= 1'b1;
      seq_r       <= '0;
      pan_lo_r    <= '0;
      dst_r       <= '0;
      src_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      idx_r       <= idx_nxt;
      len_r       <= len_nxt;
      hp_r        <= hp_nxt;
      seq_r       <= seq_nxt;
      pan_lo_r    <= pan_lo_nxt;
      dst_r       <= dst_nxt;
      src_r       <= src_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data_r <= out_data_nxt;
  end

  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.result_kind == KIND_PAYLOAD |->
      !out_data_r.frame_last && !out_data_r.accepted)
    else $error("payload request carries verdict fields");

  a_reject_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.result_kind == KIND_VERDICT && !out_data_r.accepted |->
      out_data_r.source_address == 16'd0 && out_data_r.dest_address == 16'd0 &&
      out_data_r.payload_length == 8'd0)
    else $error("rejected verdict leaks header fields");

  a_zero_len_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.frame_start && in_data.rx_byte == 8'd0 |=>
      !in_frame_r && out_valid_r && out_data_r.result_kind == KIND_VERDICT)
    else $error("zero-length frame not closed with a verdict");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> idx_r < len_r)
    else $error("byte index ran past frame length");

endmodule
